### src/assert_macros.svh
// Assertion macros used by the RTL of the record queue unit.
// No dependencies; defining ASSERT_OFF compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge, masked while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Check that a condition never holds.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`ASSERT_PROP(lbl, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### src/bbrq_pkg.sv
// Shared constants, codes and types of the bipartite-buffer record queue.
// No dependencies.
package bbrq_pkg;

	localparam int CAPACITY      = 256;
	localparam int MAX_REC_BYTES = 8;
	localparam int PTR_W         = $clog2(CAPACITY) + 1;
	localparam int SUM_W         = PTR_W + 1;
	localparam int ADDR_W        = $clog2(CAPACITY);
	localparam int LEN_W         = 4;
	localparam int IDX_W         = 3;
	localparam int REC_W         = 64;
	localparam int MODE_W        = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_ENQ    = 2'd0,
		MODE_DEQ    = 2'd1,
		MODE_PEEK   = 2'd2,
		MODE_STATUS = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_WRITE,
		SEQ_READ,
		SEQ_DRAIN
	} seq_state_t;

	// Command from the pointer logic to the byte sequencer.
	typedef struct packed {
		logic              start;
		logic              wr;
		logic [ADDR_W-1:0] base;
		logic [IDX_W-1:0]  last_idx;
		logic [REC_W-1:0]  data;
	} seq_cmd_t;

	// Status from the byte sequencer.
	typedef struct packed {
		logic             idle;
		logic             done;
		logic [REC_W-1:0] record;
	} seq_sts_t;

endpackage

### src/bbrq_ifs.sv
// Valid/ready channel interfaces for the record queue: request and result.
// Depends on bbrq_pkg for payload widths.
interface bbrq_in_if;
	logic                         valid;
	logic                         ready;
	logic [bbrq_pkg::MODE_W-1:0]  mode;
	logic [bbrq_pkg::REC_W-1:0]   record_in;

	modport source (output valid, mode, record_in, input ready);
	modport sink (input valid, mode, record_in, output ready);
endinterface

interface bbrq_out_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [bbrq_pkg::REC_W-1:0]   record_out;
	logic [bbrq_pkg::PTR_W-1:0]   used_bytes;
	logic                         empty_res;

	modport source (output valid, ok, record_out, used_bytes, empty_res, input ready);
	modport sink (input valid, ok, record_out, used_bytes, empty_res, output ready);
endinterface

### src/bbrq_byte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbrq_byte_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry and read one entry per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/bbrq_seq.sv
// Byte sequencer: moves one record between the shift register and the byte
// store, one byte per cycle through a shared address incrementer.
// Depends on bbrq_pkg and bbrq_byte_ram.
module bbrq_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  bbrq_pkg::seq_cmd_t cmd,
	output bbrq_pkg::seq_sts_t sts
);

	bbrq_pkg::seq_state_t state_q, state_d;

	logic [bbrq_pkg::ADDR_W-1:0] addr_q, addr_inc;
	logic [bbrq_pkg::IDX_W-1:0]  idx_q, last_q, pidx_s1;
	logic [bbrq_pkg::REC_W-1:0]  data_q, rec_q, rec_next;
	logic                        pend_s1;
	logic                        is_last;
	logic                        ram_we;
	logic [7:0]                  ram_rdata;

	// Shared address incrementer and byte-count compare.
	assign addr_inc = addr_q + 1'b1;
	assign is_last  = (idx_q == last_q);

	bbrq_byte_ram #(
		.DEPTH (bbrq_pkg::CAPACITY),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (data_q[7:0]),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// Merge the byte returned by the memory into the record.
	always_comb begin
		rec_next = rec_q;
		if (pend_s1) begin
			rec_next[{pidx_s1, 3'b000} +: 8] = ram_rdata;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bbrq_pkg::SEQ_IDLE: begin
				if (cmd.start) begin
					state_d = cmd.wr ? bbrq_pkg::SEQ_WRITE : bbrq_pkg::SEQ_READ;
				end
			end
			bbrq_pkg::SEQ_WRITE: begin
				if (is_last) begin
					state_d = bbrq_pkg::SEQ_IDLE;
				end
			end
			bbrq_pkg::SEQ_READ: begin
				if (is_last) begin
					state_d = bbrq_pkg::SEQ_DRAIN;
				end
			end
			bbrq_pkg::SEQ_DRAIN: begin
				state_d = bbrq_pkg::SEQ_IDLE;
			end
			default: begin
				state_d = bbrq_pkg::SEQ_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		ram_we     = 1'b0;
		sts.idle   = 1'b0;
		sts.done   = 1'b0;
		sts.record = rec_next;
		case (state_q)
			bbrq_pkg::SEQ_IDLE: begin
				sts.idle = 1'b1;
			end
			bbrq_pkg::SEQ_WRITE: begin
				ram_we   = 1'b1;
				sts.done = is_last;
			end
			bbrq_pkg::SEQ_READ: begin
				sts.done = 1'b0;
			end
			bbrq_pkg::SEQ_DRAIN: begin
				sts.done = 1'b1;
			end
			default: begin
				sts.idle = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbrq_pkg::SEQ_IDLE;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == bbrq_pkg::SEQ_READ);
		end
	end

	// Load on start, advance address and byte index while moving bytes.
	always_ff @(posedge clk) begin
		pidx_s1 <= idx_q;
		if (state_q == bbrq_pkg::SEQ_IDLE && cmd.start) begin
			addr_q <= cmd.base;
			idx_q  <= '0;
			last_q <= cmd.last_idx;
			data_q <= cmd.data;
			rec_q  <= '0;
		end else begin
			rec_q <= rec_next;
			if (state_q == bbrq_pkg::SEQ_WRITE || state_q == bbrq_pkg::SEQ_READ) begin
				addr_q <= addr_inc;
				idx_q  <= idx_q + 1'b1;
				data_q <= data_q >> 8;
			end
		end
	end

endmodule

### src/bip_buffer_record_queue_unit.sv
// Bipartite-buffer record queue. Status-only and failed requests: result
// registered on the accepting edge, next request taken once the result slot
// is free. Enqueue, dequeue and peek of an n-byte record move one byte per
// cycle through the byte store, with registered read data; no new request
// is taken until the sequencer is idle. Asynchronous reset clears the region
// pointers and sets the record length to 1; the byte store is not cleared.
`include "assert_macros.svh"
module bip_buffer_record_queue_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bbrq_pkg::LEN_W-1:0]  cfg_wdata,
	bbrq_in_if.sink                     in_ch,
	bbrq_out_if.source                  out_ch
);

	localparam logic [bbrq_pkg::SUM_W-1:0] CAP = bbrq_pkg::SUM_W'(bbrq_pkg::CAPACITY);

	logic [bbrq_pkg::LEN_W-1:0] len_q;
	logic [bbrq_pkg::PTR_W-1:0] rs_q, ae_q, be_q;
	logic                       bact_q;
	logic                       out_valid_q, ok_q, empty_q;
	logic [bbrq_pkg::REC_W-1:0] rec_q;
	logic [bbrq_pkg::PTR_W-1:0] used_q;

	bbrq_pkg::mode_t            mode;
	bbrq_pkg::seq_cmd_t         cmd;
	bbrq_pkg::seq_sts_t         sts;
	logic                       acc;
	logic [bbrq_pkg::LEN_W-1:0] n_c;
	logic [bbrq_pkg::SUM_W-1:0] nx, rs10, ae10, be10, room, rs_inc;
	logic [bbrq_pkg::SUM_W-1:0] nrs, nae, nbe, used_sum;
	logic                       nbact, can_enq, can_rd, ok_c, upd_c;

	assign mode = bbrq_pkg::mode_t'(in_ch.mode);

	// Clamp the record length to 1..MAX_REC_BYTES.
	always_comb begin
		n_c = len_q;
		if (len_q == '0) begin
			n_c = bbrq_pkg::LEN_W'(1);
		end else if (len_q > bbrq_pkg::LEN_W'(bbrq_pkg::MAX_REC_BYTES)) begin
			n_c = bbrq_pkg::LEN_W'(bbrq_pkg::MAX_REC_BYTES);
		end
	end

	assign nx   = bbrq_pkg::SUM_W'(n_c);
	assign rs10 = bbrq_pkg::SUM_W'(rs_q);
	assign ae10 = bbrq_pkg::SUM_W'(ae_q);
	assign be10 = bbrq_pkg::SUM_W'(be_q);

	// Room checks for the region being written and for the front record.
	assign room    = bact_q ? (rs10 - be10) : (CAP - ae10);
	assign can_enq = (room >= nx);
	assign can_rd  = (rs_q != ae_q) && ((ae10 - rs10) >= nx) && ((rs10 + nx) <= CAP);
	assign rs_inc  = rs10 + nx;

	// Pointer update for the request; open region B when the room in front
	// of A exceeds the room after A.
	always_comb begin
		nrs   = rs10;
		nae   = ae10;
		nbe   = be10;
		nbact = bact_q;
		ok_c  = 1'b0;
		upd_c = 1'b0;
		case (mode)
			bbrq_pkg::MODE_ENQ: begin
				if (can_enq) begin
					ok_c  = 1'b1;
					upd_c = 1'b1;
					if (bact_q) begin
						nbe = be10 + nx;
					end else begin
						nae = ae10 + nx;
					end
				end
			end
			bbrq_pkg::MODE_DEQ: begin
				if (can_rd) begin
					ok_c  = 1'b1;
					upd_c = 1'b1;
					nrs   = rs_inc;
					if (rs_inc == ae10) begin
						nrs = '0;
						if (bact_q) begin
							nae   = be10;
							nbe   = '0;
							nbact = 1'b0;
						end else begin
							nae = '0;
						end
					end
				end
			end
			bbrq_pkg::MODE_PEEK: begin
				ok_c = can_rd;
			end
			bbrq_pkg::MODE_STATUS: begin
				ok_c = 1'b0;
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
		if (upd_c && ((CAP - nae) < (nrs - nbe))) begin
			nbact = 1'b1;
		end
	end

	assign used_sum = (nae - nrs) + nbe;

	// Byte work goes to the sequencer; the output slot must be free.
	assign in_ch.ready = sts.idle && (!out_valid_q || out_ch.ready);
	assign acc         = in_ch.valid && in_ch.ready;

	always_comb begin
		cmd.start    = acc && ok_c;
		cmd.wr       = (mode == bbrq_pkg::MODE_ENQ);
		cmd.base     = (mode == bbrq_pkg::MODE_ENQ) ?
		               (bact_q ? be_q[bbrq_pkg::ADDR_W-1:0] : ae_q[bbrq_pkg::ADDR_W-1:0]) :
		               rs_q[bbrq_pkg::ADDR_W-1:0];
		cmd.last_idx = bbrq_pkg::IDX_W'(n_c - 1'b1);
		cmd.data     = in_ch.record_in;
	end

	bbrq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

	// Configuration and region pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= bbrq_pkg::LEN_W'(1);
			rs_q   <= '0;
			ae_q   <= '0;
			be_q   <= '0;
			bact_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (acc) begin
				rs_q   <= nrs[bbrq_pkg::PTR_W-1:0];
				ae_q   <= nae[bbrq_pkg::PTR_W-1:0];
				be_q   <= nbe[bbrq_pkg::PTR_W-1:0];
				bact_q <= nbact;
			end
		end
	end

	// Result valid: set on accept when no byte work is needed, else on done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= !cmd.start;
		end else if (sts.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			ok_q    <= ok_c;
			used_q  <= used_sum[bbrq_pkg::PTR_W-1:0];
			empty_q <= (nrs == nae);
			rec_q   <= '0;
		end else if (sts.done) begin
			rec_q <= sts.record;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.ok         = ok_q;
	assign out_ch.record_out = rec_q;
	assign out_ch.used_bytes = used_q;
	assign out_ch.empty_res  = empty_q;

	`ASSERT_NEVER(a_no_accept_over_result, clk, arst_n, acc && out_valid_q && !out_ch.ready)
	`ASSERT_NEVER(a_read_not_past_end, clk, arst_n, rs_q > ae_q)
	`ASSERT_NEVER(a_b_empty_when_closed, clk, arst_n, !bact_q && (be_q != '0))
	`ASSERT_NEVER(a_b_behind_read, clk, arst_n, bact_q && (be_q > rs_q))

endmodule
